/* design/clcd_pkg.sv */
// shared types, codes and constants of the character lcd command sequencer
package clcd_pkg;

    // request kinds carried on s_tuser
    typedef enum logic [2:0] {
        ACT_COMMAND   = 3'd0,
        ACT_CHARACTER = 3'd1,
        ACT_CURSOR    = 3'd2,
        ACT_INIT      = 3'd3,
        ACT_NUMBER    = 3'd4,
        ACT_GLYPH     = 3'd5
    } action_t;

    // configuration register indexes
    localparam logic [2:0] REG_ROW1_OFFSET   = 3'd0;
    localparam logic [2:0] REG_ROW2_OFFSET   = 3'd1;
    localparam logic [2:0] REG_ROW3_OFFSET   = 3'd2;
    localparam logic [2:0] REG_FUNCTION_SET  = 3'd3;
    localparam logic [2:0] REG_DISPLAY_CTRL  = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int OFFSET_W    = 7;

    // register reset values
    localparam logic [6:0] RST_ROW1_OFFSET  = 7'h40;
    localparam logic [6:0] RST_ROW2_OFFSET  = 7'h14;
    localparam logic [6:0] RST_ROW3_OFFSET  = 7'h54;
    localparam logic [7:0] RST_FUNCTION_SET = 8'h38;
    localparam logic [7:0] RST_DISPLAY_CTRL = 8'h0C;

    // lcd instruction bytes, ddram address bit and ascii digit base
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_CGRAM_BASE = 8'h40;
    localparam logic       CMD_DDRAM_BIT  = 1'b1;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;

    // register select codes
    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // stream widths
    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;

    // number printing
    localparam int NUM_W           = 32;
    localparam int NUM_MAX_DIGITS  = 10;
    localparam int DEF_MAX_DIGITS  = 10;
    localparam int DIGIT_W         = 4;

    // divide by ten: q = (v * RECIP10) >> RECIP10_SHIFT, exact for every 32-bit v
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    // init and glyph run positions
    localparam int          STEP_W             = 4;
    localparam logic [3:0]  STEP_FIRST         = 4'd0;
    localparam logic [3:0]  INIT_DISPLAY_STEP  = 4'd2;
    localparam logic [3:0]  INIT_LAST_STEP     = 4'd3;
    localparam logic [3:0]  GLYPH_ROW_FIRST    = 4'd1;
    localparam logic [3:0]  GLYPH_ROW_LAST     = 4'd8;
    localparam logic [3:0]  GLYPH_CURSOR_STEP  = 4'd9;

endpackage

/* design/clcd_div10.sv */
// shared divide-by-ten unit: reciprocal multiply, registered, then remainder fix-up
module clcd_div10 (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [clcd_pkg::NUM_W-1:0]  dividend,
    output logic                        done,
    output logic [clcd_pkg::NUM_W-1:0]  quotient,
    output logic [clcd_pkg::DIGIT_W-1:0] remainder
);
    import clcd_pkg::*;

    logic                 busy_reg;
    logic [2*NUM_W-1:0]   prod_reg;
    logic [NUM_W-1:0]     val_reg;
    logic [NUM_W-1:0]     q_times_ten;
    logic [NUM_W-1:0]     diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= start;
        end
        if (start) begin
            prod_reg <= dividend * RECIP10;
            val_reg  <= dividend;
        end
    end

    assign quotient    = NUM_W'(prod_reg >> RECIP10_SHIFT);
    // q * 10 as two shifts and an add
    assign q_times_ten = (quotient << 3) + (quotient << 1);
    assign diff        = val_reg - q_times_ten;
    assign remainder   = diff[DIGIT_W-1:0];
    assign done        = busy_reg;

endmodule

/* design/char_lcd_command_sequencer_unit.sv */
// character lcd command sequencer: requests in, register-select and byte transfers out
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser action, s_tdata request fields
//  m_      | out | m_tvalid/m_tready  | m_tuser register select, m_tdata byte, m_tlast
//  cfg_    | in  | cfg_we             | cfg_index, cfg_data
//
// A request is taken while idle, then each transfer beat leaves one per cycle
// unless m_tready stalls it (one beat for command, character and cursor, four for
// init, eleven for glyph). A number first sends each decimal digit through the
// shared divide-by-ten multiplier, then one digit beat per cycle unless stalled.
// s_tready is high only while no request is in progress; the final beat may wait in
// the output register while the next request is taken. Reset is synchronous, active
// low, and restores the register defaults.
module char_lcd_command_sequencer_unit #(
    parameter int MAX_DIGITS = clcd_pkg::DEF_MAX_DIGITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // bits: byte_value[7:0] row[9:8] column[15:10] number_value[47:16]
    //       glyph_slot[50:48] glyph_rows[114:51], zero fill above
    input  logic [clcd_pkg::S_TDATA_W-1:0]    s_tdata,
    // bits: action[2:0]
    input  logic [clcd_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // bits: lcd_byte[7:0]
    output logic [clcd_pkg::M_TDATA_W-1:0]    m_tdata,
    // bits: register_select[0]
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [clcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import clcd_pkg::*;

    localparam int DIG_DEPTH = (MAX_DIGITS < NUM_MAX_DIGITS) ? MAX_DIGITS : NUM_MAX_DIGITS;
    localparam int DIG_IW    = (DIG_DEPTH > 1) ? $clog2(DIG_DEPTH) : 1;
    localparam int CNT_W     = $clog2(DIG_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [OFFSET_W-1:0] row1_off_reg, row2_off_reg, row3_off_reg;
    logic [7:0]          func_set_reg, disp_ctrl_reg;

    // request payload
    action_t             act_reg, act_next;
    logic [7:0]          byte_reg, byte_next;
    logic [1:0]          row_reg, row_next;
    logic [5:0]          col_reg, col_next;
    logic [2:0]          slot_reg, slot_next;
    logic [63:0]         rows_reg, rows_next;
    logic [NUM_W-1:0]    num_reg, num_next;

    // sequencing
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    ndig_reg, ndig_next;
    logic [DIG_IW-1:0]   dig_idx_reg, dig_idx_next;
    logic [DIGIT_W-1:0]  digit_reg [DIG_DEPTH];
    logic                digit_we;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          m_data_reg, m_data_next;
    logic                m_rs_reg, m_rs_next;
    logic                m_last_reg, m_last_next;

    // current beat
    logic                beat_rs;
    logic [7:0]          beat_byte;
    logic                beat_last;
    logic [7:0]          cursor_byte;
    logic [OFFSET_W-1:0] row_base;
    logic                out_free;
    logic                s_accept;

    logic                div_start;
    logic                div_done;
    logic [NUM_W-1:0]    div_quot;
    logic [DIGIT_W-1:0]  div_rem;

    clcd_div10 u_div10 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (num_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign div_start = (state_reg == ST_DIV_START);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_rs_reg;
    assign m_tlast  = m_last_reg;

    // cursor address wraps to seven bits
    always_comb begin
        case (row_reg)
            2'd1:    row_base = row1_off_reg;
            2'd2:    row_base = row2_off_reg;
            2'd3:    row_base = row3_off_reg;
            default: row_base = '0;
        endcase
        cursor_byte = {CMD_DDRAM_BIT, OFFSET_W'(row_base + {1'b0, col_reg})};
    end

    always_comb begin
        beat_rs   = RS_INSTR;
        beat_byte = byte_reg;
        beat_last = 1'b1;
        case (act_reg)
            ACT_COMMAND: begin
                beat_rs = RS_INSTR;
            end
            ACT_CHARACTER: begin
                beat_rs = RS_DATA;
            end
            ACT_CURSOR: begin
                beat_byte = cursor_byte;
            end
            ACT_INIT: begin
                beat_last = (step_reg == INIT_LAST_STEP);
                if (step_reg < INIT_DISPLAY_STEP) begin
                    beat_byte = func_set_reg;
                end else if (step_reg == INIT_DISPLAY_STEP) begin
                    beat_byte = disp_ctrl_reg;
                end else begin
                    beat_byte = CMD_CLEAR;
                end
            end
            ACT_NUMBER: begin
                beat_rs   = RS_DATA;
                beat_byte = ASCII_ZERO + {4'b0, digit_reg[dig_idx_reg]};
                beat_last = (dig_idx_reg == '0);
            end
            ACT_GLYPH: begin
                beat_last = 1'b0;
                if (step_reg == STEP_FIRST) begin
                    beat_byte = CMD_CGRAM_BASE + {2'b0, slot_reg, 3'b0};
                end else if (step_reg <= GLYPH_ROW_LAST) begin
                    beat_rs   = RS_DATA;
                    beat_byte = rows_reg[7:0];
                end else if (step_reg == GLYPH_CURSOR_STEP) begin
                    beat_byte = cursor_byte;
                end else begin
                    beat_rs   = RS_DATA;
                    beat_byte = {5'b0, slot_reg};
                    beat_last = 1'b1;
                end
            end
            default: begin
                beat_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        byte_next    = byte_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        slot_next    = slot_reg;
        rows_next    = rows_reg;
        num_next     = num_reg;
        step_next    = step_reg;
        ndig_next    = ndig_reg;
        dig_idx_next = dig_idx_reg;
        digit_we     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_rs_next    = m_rs_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    act_next  = action_t'(s_tuser);
                    byte_next = s_tdata[7:0];
                    row_next  = s_tdata[9:8];
                    col_next  = s_tdata[15:10];
                    num_next  = s_tdata[47:16];
                    slot_next = s_tdata[50:48];
                    rows_next = s_tdata[114:51];
                    step_next = STEP_FIRST;
                    ndig_next = '0;
                    case (action_t'(s_tuser))
                        ACT_COMMAND, ACT_CHARACTER, ACT_CURSOR, ACT_INIT, ACT_GLYPH:
                            state_next = ST_EMIT;
                        ACT_NUMBER:
                            state_next = ST_DIV_START;
                        // unused codes cause no transfer
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    digit_we = 1'b1;
                    num_next = div_quot;
                    if (div_quot == '0 || ndig_reg == CNT_W'(DIG_DEPTH - 1)) begin
                        dig_idx_next = ndig_reg[DIG_IW-1:0];
                        state_next   = ST_EMIT;
                    end else begin
                        ndig_next  = ndig_reg + 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = beat_byte;
                    m_rs_next    = beat_rs;
                    m_last_next  = beat_last;
                    step_next    = step_reg + 1'b1;
                    if (act_reg == ACT_NUMBER) begin
                        dig_idx_next = dig_idx_reg - 1'b1;
                    end
                    // glyph rows leave lowest byte first
                    if (act_reg == ACT_GLYPH && step_reg >= GLYPH_ROW_FIRST
                            && step_reg <= GLYPH_ROW_LAST) begin
                        rows_next = rows_reg >> 8;
                    end
                    if (beat_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            row1_off_reg  <= RST_ROW1_OFFSET;
            row2_off_reg  <= RST_ROW2_OFFSET;
            row3_off_reg  <= RST_ROW3_OFFSET;
            func_set_reg  <= RST_FUNCTION_SET;
            disp_ctrl_reg <= RST_DISPLAY_CTRL;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_ROW1_OFFSET:  row1_off_reg  <= cfg_data[OFFSET_W-1:0];
                    REG_ROW2_OFFSET:  row2_off_reg  <= cfg_data[OFFSET_W-1:0];
                    REG_ROW3_OFFSET:  row3_off_reg  <= cfg_data[OFFSET_W-1:0];
                    REG_FUNCTION_SET: func_set_reg  <= cfg_data;
                    REG_DISPLAY_CTRL: disp_ctrl_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        act_reg     <= act_next;
        byte_reg    <= byte_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        slot_reg    <= slot_next;
        rows_reg    <= rows_next;
        num_reg     <= num_next;
        step_reg    <= step_next;
        ndig_reg    <= ndig_next;
        dig_idx_reg <= dig_idx_next;
        m_data_reg  <= m_data_next;
        m_rs_reg    <= m_rs_next;
        m_last_reg  <= m_last_next;
        if (digit_we) begin
            digit_reg[ndig_reg[DIG_IW-1:0]] <= div_rem;
        end
    end

endmodule
